>>> rtl/fixed_step_frame_timer_assert.svh
// ----------------------------------------------------------------------------
// Fixed-step frame timer assertion macros
// Concurrent checks on the sequencer and divider, reported by $error.
// ----------------------------------------------------------------------------
`ifndef FIXED_STEP_FRAME_TIMER_ASSERT_SVH
`define FIXED_STEP_FRAME_TIMER_ASSERT_SVH

// Same-cycle implication
`define FSFT_ASSERT_IMPL(label, clock, reset, cause, effect, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
    else $error(msg);

// Next-cycle implication
`define FSFT_ASSERT_NEXT(label, clock, reset, cause, effect, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
    else $error(msg);

`endif

>>> rtl/fsft_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-step frame timer package
// Constants, divider request types and the sequencer control store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsft_pkg;

  // Defaults and fixed constants
  localparam int unsigned TICKS_PER_SECOND_DEF = 10_000_000;
  localparam logic [31:0] TARGET_STEP_RESET    = 32'd166666;
  localparam logic [31:0] COUNTER_FREQ_RESET   = 32'd10000000;
  localparam int unsigned SNAP_DIVISOR         = 4000;

  // floor(f / 10) == (f * RECIP_TEN) >> RECIP_TEN_SHIFT for any 32-bit f
  localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
  localparam int          RECIP_TEN_SHIFT = 35;

  // Result item width: five fields, byte aligned
  localparam int OUT_W = 224;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIXED_STEP_MODE = 2'd0,
    CFG_TARGET_STEP     = 2'd1,
    CFG_COUNTER_FREQ    = 2'd2
  } cfg_index_t;

  // Divider geometry
  localparam int DIVIDEND_W      = 64;
  localparam int DIVISOR_W       = 32;
  localparam int DIV_LONG_RUNS   = DIVIDEND_W;
  localparam int DIV_SHORT_RUNS  = 34;
  localparam int DIV_SHORT_SHIFT = DIVIDEND_W - DIV_SHORT_RUNS;
  localparam int DIV_CNT_W       = $clog2(DIV_LONG_RUNS + 1);

  typedef struct packed {
    logic                  start;
    logic                  short_run;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLEAR_STEPS,
    OP_DIFF,
    OP_MUL_RECIP,
    OP_CLAMP,
    OP_MUL_SCALE,
    OP_DIV_SCALE,
    OP_TAKE_QUOT,
    OP_SNAP,
    OP_DIV_STEP,
    OP_STEPS,
    OP_VAR_STEP,
    OP_DIV_SEC,
    OP_LATCH,
    OP_EMIT,
    OP_RESET_ELAPSED
  } op_t;

  // Jump conditions: jump when true, otherwise fall through
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_MODE_RESET,
    C_DIV_BUSY,
    C_VAR_MODE,
    C_TARGET_ZERO,
    C_SEC_SHORT,
    C_OUT_BUSY
  } cond_t;

  localparam int PC_W = 5;

  // Program addresses
  localparam logic [PC_W-1:0] PC_WAIT       = 5'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH   = 5'd1;
  localparam logic [PC_W-1:0] PC_DIFF       = 5'd2;
  localparam logic [PC_W-1:0] PC_MUL_RECIP  = 5'd3;
  localparam logic [PC_W-1:0] PC_CLAMP      = 5'd4;
  localparam logic [PC_W-1:0] PC_MUL_SCALE  = 5'd5;
  localparam logic [PC_W-1:0] PC_DIV_SCALE  = 5'd6;
  localparam logic [PC_W-1:0] PC_WAIT_SCALE = 5'd7;
  localparam logic [PC_W-1:0] PC_TAKE_QUOT  = 5'd8;
  localparam logic [PC_W-1:0] PC_SNAP       = 5'd9;
  localparam logic [PC_W-1:0] PC_DIV_STEP   = 5'd10;
  localparam logic [PC_W-1:0] PC_WAIT_STEP  = 5'd11;
  localparam logic [PC_W-1:0] PC_STEPS      = 5'd12;
  localparam logic [PC_W-1:0] PC_VAR_STEP   = 5'd13;
  localparam logic [PC_W-1:0] PC_SECOND     = 5'd14;
  localparam logic [PC_W-1:0] PC_DIV_SEC    = 5'd15;
  localparam logic [PC_W-1:0] PC_WAIT_SEC   = 5'd16;
  localparam logic [PC_W-1:0] PC_LATCH      = 5'd17;
  localparam logic [PC_W-1:0] PC_EMIT       = 5'd18;
  localparam logic [PC_W-1:0] PC_RETURN     = 5'd19;
  localparam logic [PC_W-1:0] PC_RESET_EL   = 5'd20;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jump;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      PC_WAIT:       w = '{OP_ACCEPT,        C_NO_INPUT,    PC_WAIT};
      PC_DISPATCH:   w = '{OP_CLEAR_STEPS,   C_MODE_RESET,  PC_RESET_EL};
      PC_DIFF:       w = '{OP_DIFF,          C_NEVER,       PC_WAIT};
      PC_MUL_RECIP:  w = '{OP_MUL_RECIP,     C_NEVER,       PC_WAIT};
      PC_CLAMP:      w = '{OP_CLAMP,         C_NEVER,       PC_WAIT};
      PC_MUL_SCALE:  w = '{OP_MUL_SCALE,     C_NEVER,       PC_WAIT};
      PC_DIV_SCALE:  w = '{OP_DIV_SCALE,     C_NEVER,       PC_WAIT};
      PC_WAIT_SCALE: w = '{OP_NONE,          C_DIV_BUSY,    PC_WAIT_SCALE};
      PC_TAKE_QUOT:  w = '{OP_TAKE_QUOT,     C_VAR_MODE,    PC_VAR_STEP};
      PC_SNAP:       w = '{OP_SNAP,          C_TARGET_ZERO, PC_SECOND};
      PC_DIV_STEP:   w = '{OP_DIV_STEP,      C_NEVER,       PC_WAIT};
      PC_WAIT_STEP:  w = '{OP_NONE,          C_DIV_BUSY,    PC_WAIT_STEP};
      PC_STEPS:      w = '{OP_STEPS,         C_ALWAYS,      PC_SECOND};
      PC_VAR_STEP:   w = '{OP_VAR_STEP,      C_NEVER,       PC_WAIT};
      PC_SECOND:     w = '{OP_NONE,          C_SEC_SHORT,   PC_EMIT};
      PC_DIV_SEC:    w = '{OP_DIV_SEC,       C_NEVER,       PC_WAIT};
      PC_WAIT_SEC:   w = '{OP_NONE,          C_DIV_BUSY,    PC_WAIT_SEC};
      PC_LATCH:      w = '{OP_LATCH,         C_NEVER,       PC_WAIT};
      PC_EMIT:       w = '{OP_EMIT,          C_OUT_BUSY,    PC_EMIT};
      PC_RETURN:     w = '{OP_NONE,          C_ALWAYS,      PC_WAIT};
      PC_RESET_EL:   w = '{OP_RESET_ELAPSED, C_ALWAYS,      PC_EMIT};
      default:       w = '{OP_NONE,          C_ALWAYS,      PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/fsft_divider.sv
// ----------------------------------------------------------------------------
// Fixed-step frame timer divider
// Restoring unsigned divider, one quotient bit per cycle. A short run covers
// dividends below 2^34 in fewer cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsft_divider import fsft_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  // Trial subtract of the shifted partial remainder
  assign rem_sh  = {rem, quo[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = rem_sh >= {1'b0, dsr};

  // Count the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= req.short_run ? DIV_CNT_W'(DIV_SHORT_RUNS) : DIV_CNT_W'(DIV_LONG_RUNS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.short_run ? (req.dividend << DIV_SHORT_SHIFT) : req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> rtl/fixed_step_frame_timer.sv
// ----------------------------------------------------------------------------
// Fixed-step frame timer
// Turns raw counter samples into fixed or variable update steps, keeps total
// ticks and frame counts, and latches frames per second.
//
//   Port group  Direction  Payload
//   s_*         in         tuser: mode; tdata: counter_now
//   m_*         out        tdata: steps_run, elapsed_ticks, total_ticks,
//                                 frame_count, frames_per_second
//   cfg_*       in         cfg_index, cfg_data (register write)
//
// One item at a time, run by a microcoded sequencer. A variable-step tick
// runs one long division, a fixed-step tick adds a short one, and a tick
// that closes a second adds another long one. A reset-elapsed item runs no
// division. All divisions share the one bit-serial divider.
// Reset is synchronous and clears all timer state. A result not yet taken
// holds in the output register; the next item runs up to its emit step and
// waits there, taking no new request until the held result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_step_frame_timer_assert.svh"

module fixed_step_frame_timer import fsft_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Request stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // [63:0] counter_now
  input  logic             s_tuser,   // [0] mode
  // Result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [31:0] steps_run, [95:32] elapsed_ticks,
                                      // [159:96] total_ticks, [191:160] frame_count,
                                      // [223:192] frames_per_second
  // Register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [63:0] SNAP_LIMIT = 64'(TICKS_PER_SECOND / SNAP_DIVISOR);

  // Configuration
  logic        fixed_step_mode;
  logic [31:0] target_step_ticks;
  logic [31:0] counter_frequency;

  // Sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          uw;
  logic            take_jump;

  // Working registers
  logic        item_mode;
  logic [63:0] now;
  logic [63:0] delta;
  logic [63:0] mul_p;
  logic [31:0] steps;

  // Timer state
  logic [63:0] last_sample;
  logic [63:0] second_accum;
  logic [63:0] leftover;
  logic [63:0] last_elapsed;
  logic [63:0] total;
  logic [31:0] frames;
  logic [31:0] frames_this_second;
  logic [31:0] fps_latched;

  // Combinational helpers
  logic [31:0] freq_eff;
  logic [63:0] freq_ext;
  logic [63:0] target_ext;
  logic [63:0] sample_diff;
  logic [63:0] clamp_val;
  logic [63:0] abs_diff;
  logic [63:0] snapped;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        accept;
  logic        out_free;
  logic        emit_load;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign freq_eff    = (counter_frequency == '0) ? 32'd1 : counter_frequency;
  assign freq_ext    = {32'b0, freq_eff};
  assign target_ext  = {32'b0, target_step_ticks};
  assign sample_diff = now - last_sample;
  assign clamp_val   = {{RECIP_TEN_SHIFT{1'b0}}, mul_p[63:RECIP_TEN_SHIFT]};
  assign abs_diff    = (delta >= target_ext) ? (delta - target_ext) : (target_ext - delta);
  assign snapped     = (abs_diff < SNAP_LIMIT) ? target_ext : delta;

  assign uw        = ucode_rom(pc);
  assign s_tready  = (uw.op == OP_ACCEPT) && !rst;
  assign accept    = s_tready && s_tvalid;
  assign out_free  = !m_tvalid || m_tready;
  assign emit_load = (uw.op == OP_EMIT) && out_free;
  assign cfg_ready = !rst;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step_mode   <= 1'b0;
      target_step_ticks <= TARGET_STEP_RESET;
      counter_frequency <= COUNTER_FREQ_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIXED_STEP_MODE: fixed_step_mode   <= cfg_data[0];
        CFG_TARGET_STEP:     target_step_ticks <= cfg_data;
        CFG_COUNTER_FREQ:    counter_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:       take_jump = 1'b0;
      C_ALWAYS:      take_jump = 1'b1;
      C_NO_INPUT:    take_jump = !s_tvalid;
      C_MODE_RESET:  take_jump = item_mode;
      C_DIV_BUSY:    take_jump = div_rsp.busy;
      C_VAR_MODE:    take_jump = !fixed_step_mode;
      C_TARGET_ZERO: take_jump = (target_step_ticks == '0);
      C_SEC_SHORT:   take_jump = (second_accum < freq_ext);
      C_OUT_BUSY:    take_jump = !out_free;
      default:       take_jump = 1'b1;
    endcase
    pc_next = take_jump ? uw.jump : pc + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Select multiplier operands
  always_comb begin
    if (uw.op == OP_MUL_RECIP) begin
      mul_a = freq_eff;
      mul_b = RECIP_TEN;
    end else begin
      mul_a = delta[31:0];
      mul_b = 32'(TICKS_PER_SECOND);
    end
  end

  // Build the divider request
  always_comb begin
    div_req.start     = 1'b0;
    div_req.short_run = 1'b0;
    div_req.dividend  = mul_p;
    div_req.divisor   = freq_eff;
    unique case (uw.op)
      OP_DIV_SCALE: begin
        div_req.start = 1'b1;
      end
      OP_DIV_STEP: begin
        div_req.start     = 1'b1;
        div_req.short_run = 1'b1;
        div_req.dividend  = leftover;
        div_req.divisor   = target_step_ticks;
      end
      OP_DIV_SEC: begin
        div_req.start    = 1'b1;
        div_req.dividend = second_accum;
      end
      default: ;
    endcase
  end

  fsft_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Hold the accepted request and the multiplier product
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= s_tuser;
      now       <= s_tdata;
    end
    if (uw.op == OP_MUL_RECIP || uw.op == OP_MUL_SCALE) begin
      mul_p <= {32'b0, mul_a} * {32'b0, mul_b};
    end
  end

  // Timer datapath, one operation per step
  always_ff @(posedge clk) begin
    if (rst) begin
      delta              <= '0;
      steps              <= '0;
      last_sample        <= '0;
      second_accum       <= '0;
      leftover           <= '0;
      last_elapsed       <= '0;
      total              <= '0;
      frames             <= '0;
      frames_this_second <= '0;
      fps_latched        <= '0;
    end else begin
      unique case (uw.op)
        OP_CLEAR_STEPS: begin
          steps <= '0;
        end
        OP_DIFF: begin
          delta        <= sample_diff;
          last_sample  <= now;
          second_accum <= second_accum + sample_diff;
        end
        OP_CLAMP: begin
          if (delta > clamp_val) begin
            delta <= clamp_val;
          end
        end
        OP_TAKE_QUOT: begin
          delta <= div_rsp.quotient;
        end
        OP_SNAP: begin
          // leftover holds the dividend (leftover plus step) until the division ends
          if (target_step_ticks == '0) begin
            leftover <= '0;
          end else begin
            leftover <= leftover + snapped;
          end
        end
        OP_STEPS: begin
          leftover <= {32'b0, div_rsp.remainder};
          steps    <= (div_rsp.quotient[63:32] != '0) ? '1 : div_rsp.quotient[31:0];
          if (div_rsp.quotient != '0) begin
            last_elapsed       <= target_ext;
            total              <= total + (leftover - {32'b0, div_rsp.remainder});
            frames             <= frames + div_rsp.quotient[31:0];
            frames_this_second <= frames_this_second + 1'b1;
          end
        end
        OP_VAR_STEP: begin
          last_elapsed       <= delta;
          total              <= total + delta;
          leftover           <= '0;
          frames             <= frames + 1'b1;
          frames_this_second <= frames_this_second + 1'b1;
          steps              <= 32'd1;
        end
        OP_LATCH: begin
          fps_latched        <= frames_this_second;
          frames_this_second <= '0;
          second_accum       <= {32'b0, div_rsp.remainder};
        end
        OP_RESET_ELAPSED: begin
          last_sample        <= now;
          leftover           <= '0;
          fps_latched        <= '0;
          frames_this_second <= '0;
          second_accum       <= '0;
          steps              <= '0;
        end
        OP_NONE, OP_ACCEPT, OP_MUL_RECIP, OP_MUL_SCALE, OP_DIV_SCALE,
        OP_DIV_STEP, OP_DIV_SEC, OP_EMIT: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {fps_latched, frames, total, last_elapsed, steps};
    end
  end

  // Checks
  `FSFT_ASSERT_IMPL(a_take_div_idle, clk, rst, s_tready, !div_rsp.busy, "request taken while divider runs")
  `FSFT_ASSERT_IMPL(a_start_div_idle, clk, rst, div_req.start, !div_rsp.busy, "divider restarted mid-run")
  `FSFT_ASSERT_NEXT(a_leftover_bound, clk, rst, uw.op == OP_STEPS, leftover < $past(target_ext), "leftover not below target")
  `FSFT_ASSERT_NEXT(a_one_item, clk, rst, accept, !s_tready, "second request taken back to back")

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Fixed-step frame timer testbench
// Drives counter samples and reset-elapsed requests through the stream port,
// rewrites the timer registers between phases, and checks every result
// against a cycle-free model of the timer kept alongside the block. A short
// table of directed requests comes first, then randomised phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import fsft_pkg::*;

  localparam logic [63:0] TICK_RATE    = 64'(TICKS_PER_SECOND_DEF);
  localparam logic [63:0] SNAP_WINDOW  = TICK_RATE / SNAP_DIVISOR;
  localparam int          MAX_REPORTS  = 10;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          DRAIN_CYCLES = 250;
  localparam int          LIMIT_NS     = 20_000_000;

  typedef enum logic { MODE_TICK = 1'b0, MODE_RESET_ELAPSED = 1'b1 } req_mode_t;
  typedef enum logic { ROW_REQ = 1'b0, ROW_REG = 1'b1 } row_kind_t;

  // One result, field by field
  typedef struct packed {
    logic [31:0] steps;
    logic [63:0] elapsed;
    logic [63:0] total;
    logic [31:0] frames;
    logic [31:0] fps;
  } frame_report_t;

  typedef struct packed {
    row_kind_t     kind;
    cfg_index_t    reg_index;
    logic [31:0]   reg_value;
    req_mode_t     mode;
    logic [63:0]   counter;
    logic          typed;
    frame_report_t want;
  } plan_row_t;

  localparam frame_report_t UNTYPED = '0;

  // Directed requests; typed results are {steps, elapsed, total, frames, fps}
  localparam plan_row_t DIRECTED_PLAN [27] = '{
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_RESET_ELAPSED, 64'd0, 1'b1,
      '{32'd0, 64'd0, 64'd0, 32'd0, 32'd0}},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd0, 1'b1,
      '{32'd1, 64'd0, 64'd0, 32'd1, 32'd0}},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd1_000_000, 1'b1,
      '{32'd1, 64'd1_000_000, 64'd1_000_000, 32'd2, 32'd0}},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{32'd1, 64'd1_000_000, 64'd2_000_000, 32'd3, 32'd3}},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REG, CFG_FIXED_STEP_MODE, 32'd1, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd166_666, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd334_666, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd498_866, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd661_866, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd1_361_866, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_RESET_ELAPSED, 64'h8000_0000_0000_0000,
      1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'h8000_0000_0002_8B0A, 1'b0, UNTYPED},
    '{ROW_REG, CFG_TARGET_STEP, 32'd0, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'h8000_0000_0005_1614, 1'b0, UNTYPED},
    '{ROW_REG, CFG_TARGET_STEP, 32'd1, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REG, CFG_COUNTER_FREQ, 32'd0, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ROW_REG, CFG_TARGET_STEP, 32'hFFFF_FFFF, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REG, CFG_COUNTER_FREQ, 32'hFFFF_FFFF, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'h0123_4567_89AB_CDEF, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'hFEDC_BA98_7654_3210, 1'b0, UNTYPED},
    '{ROW_REG, CFG_TARGET_STEP, 32'd1, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REG, CFG_COUNTER_FREQ, 32'd10_000_000, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'hFEDC_BA98_7663_7450, 1'b0, UNTYPED},
    '{ROW_REG, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd0, 1'b0, UNTYPED},
    '{ROW_REQ, CFG_FIXED_STEP_MODE, 32'd0, MODE_TICK, 64'd0, 1'b0, UNTYPED}
  };

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [63:0]        s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_index_t         cfg_index;
  logic [31:0]        cfg_data;

  // Timer model: registers and state
  logic               fixed_mode  = 1'b0;
  logic [31:0]        step_target = TARGET_STEP_RESET;
  logic [31:0]        ctr_freq    = COUNTER_FREQ_RESET;
  logic [63:0]        prev_sample = '0;
  logic [63:0]        sec_accum   = '0;
  logic [63:0]        carry_ticks = '0;
  logic [63:0]        step_ticks  = '0;
  logic [63:0]        total_ticks = '0;
  logic [31:0]        frame_cnt   = '0;
  logic [31:0]        sec_frames  = '0;
  logic [31:0]        fps_hold    = '0;

  frame_report_t      report_q[$];

  // Sender burst state, receiver hold-off request, run statistics
  int                 burst_left = 1;
  int                 gap_left = 0;
  bit                 hold_off = 1'b0;
  int                 holds_done = 0;
  int                 reqs_sent = 0;
  int                 resets_sent = 0;
  int                 reg_writes = 0;
  int                 results_checked = 0;
  int                 fps_results = 0;
  int                 mismatches = 0;
  logic [31:0]        max_steps = '0;

  fixed_step_frame_timer #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the timer model by one request and return the result it owes
  function automatic frame_report_t advance_timer(req_mode_t mode, logic [63:0] now);
    logic [63:0]   freq;
    logic [63:0]   delta;
    logic [63:0]   diff;
    logic [63:0]   target;
    logic [63:0]   steps;
    frame_report_t r;
    freq  = (ctr_freq == 32'd0) ? 64'd1 : 64'(ctr_freq);
    steps = '0;
    if (mode == MODE_RESET_ELAPSED) begin
      prev_sample = now;
      carry_ticks = '0;
      fps_hold    = '0;
      sec_frames  = '0;
      sec_accum   = '0;
    end else begin
      delta       = now - prev_sample;
      prev_sample = now;
      sec_accum   = sec_accum + delta;
      // clamp to a tenth of a second, then rescale to timer ticks
      if (delta > freq / 10)
        delta = freq / 10;
      delta = (delta * TICK_RATE) / freq;
      if (fixed_mode) begin
        target = 64'(step_target);
        diff   = (delta >= target) ? delta - target : target - delta;
        if (diff < SNAP_WINDOW)
          delta = target;
        if (target == 64'd0) begin
          carry_ticks = '0;
        end else begin
          carry_ticks = carry_ticks + delta;
          steps       = carry_ticks / target;
          carry_ticks = carry_ticks % target;
          if (steps != 64'd0) begin
            step_ticks  = target;
            total_ticks = total_ticks + steps * target;
            frame_cnt   = frame_cnt + steps[31:0];
          end
        end
      end else begin
        step_ticks  = delta;
        total_ticks = total_ticks + delta;
        carry_ticks = '0;
        frame_cnt   = frame_cnt + 32'd1;
        steps       = 64'd1;
      end
      if (steps != 64'd0)
        sec_frames = sec_frames + 32'd1;
      // latch the frame rate once a second of counter ticks has gone by
      if (sec_accum >= freq) begin
        fps_hold   = sec_frames;
        sec_frames = '0;
        sec_accum  = sec_accum % freq;
      end
    end
    r.steps   = (steps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : steps[31:0];
    r.elapsed = step_ticks;
    r.total   = total_ticks;
    r.frames  = frame_cnt;
    r.fps     = fps_hold;
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d %s: expected %0d, got %0d", results_checked, field, want, got);
    end
  endfunction

  // Offer one request, pausing between bursts, and record what it owes
  task automatic send_request(req_mode_t mode, logic [63:0] now, logic typed,
                              frame_report_t want);
    frame_report_t guess;
    if (cfg_valid)
      cfg_valid <= 1'b0;
    if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    guess = advance_timer(mode, now);
    report_q.push_back(typed ? want : guess);
    reqs_sent++;
    if (mode == MODE_RESET_ELAPSED)
      resets_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
  endtask

  // Drop both request lines and wait until every result is back
  task automatic drain_results();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIXED_STEP_MODE: fixed_mode  = value[0];
      CFG_TARGET_STEP:     step_target = value;
      CFG_COUNTER_FREQ:    ctr_freq    = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Receiver: stall on a rotating pattern, with one long hold-off on request
  initial begin
    int         window_left;
    logic [7:0] stall_pattern;
    window_left   = 0;
    stall_pattern = '1;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        holds_done++;
      end else begin
        if (window_left == 0) begin
          window_left   = $urandom_range(16, 96);
          stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        end
        m_tready <= stall_pattern[window_left % 8];
        window_left--;
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.steps   = m_tdata[31:0];
      got.elapsed = m_tdata[95:32];
      got.total   = m_tdata[159:96];
      got.frames  = m_tdata[191:160];
      got.fps     = m_tdata[223:192];
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with none outstanding: steps %0d total %0d", got.steps, got.total);
      end else begin
        want = report_q.pop_front();
        check_field("steps_run", 64'(want.steps), 64'(got.steps));
        check_field("elapsed_ticks", want.elapsed, got.elapsed);
        check_field("total_ticks", want.total, got.total);
        check_field("frame_count", 64'(want.frames), 64'(got.frames));
        check_field("frames_per_second", 64'(want.fps), 64'(got.fps));
      end
      results_checked++;
      if (got.steps > max_steps)
        max_steps = got.steps;
      if (got.fps != 32'd0)
        fps_results++;
    end
  end

  // Main sequence: reset, directed table, randomised phases, drain
  initial begin
    logic        mode_bit;
    logic [31:0] tgt_val;
    logic [31:0] freq_val;
    logic [63:0] freq_eff;
    logic [63:0] frame_raw;
    logic [63:0] jitter;
    logic [63:0] counter_val;
    int          n_items;
    int          pick;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FIXED_STEP_MODE;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_REG) begin
        drain_results();
        write_reg(DIRECTED_PLAN[i].reg_index, DIRECTED_PLAN[i].reg_value);
      end else begin
        send_request(DIRECTED_PLAN[i].mode, DIRECTED_PLAN[i].counter,
                     DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end
    end

    // Randomised phases, one register setting each
    counter_val = '0;
    for (int setting = 0; setting < 6; setting++) begin
      drain_results();
      case (setting)
        0: begin
          mode_bit = 1'b1; tgt_val = TARGET_STEP_RESET; freq_val = COUNTER_FREQ_RESET;
          n_items = 200;
        end
        1: begin
          mode_bit = 1'b0; tgt_val = $urandom; freq_val = COUNTER_FREQ_RESET;
          n_items = 150;
        end
        2: begin
          mode_bit = 1'b1; tgt_val = $urandom_range(50_000, 400_000);
          freq_val = $urandom_range(1_000_000, 100_000_000);
          n_items = 180;
        end
        3: begin
          mode_bit = 1'b1; tgt_val = $urandom_range(1, 40); freq_val = COUNTER_FREQ_RESET;
          n_items = 100;
        end
        4: begin
          mode_bit = 1'b0; tgt_val = $urandom; freq_val = $urandom;
          n_items = 120;
        end
        default: begin
          mode_bit = 1'b1; tgt_val = $urandom; freq_val = $urandom;
          n_items = 100;
        end
      endcase
      write_reg(CFG_FIXED_STEP_MODE, {31'd0, mode_bit});
      write_reg(CFG_TARGET_STEP, tgt_val);
      write_reg(CFG_COUNTER_FREQ, freq_val);

      // nominal raw counter advance per frame, and a jitter of 1/2000 s
      freq_eff  = (ctr_freq == 32'd0) ? 64'd1 : 64'(ctr_freq);
      frame_raw = (fixed_mode && 64'(step_target) <= TICK_RATE) ?
                  (64'(step_target) * freq_eff) / TICK_RATE : freq_eff / 60;
      jitter    = freq_eff / 2000;

      for (int k = 0; k < n_items; k++) begin
        if (setting == 0 && k == 100)
          hold_off = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          counter_val = {$urandom, $urandom};
          send_request(MODE_RESET_ELAPSED, counter_val, 1'b0, UNTYPED);
        end else begin
          if (pick < 10)
            counter_val = {$urandom, $urandom};
          else if (pick < 16)
            counter_val = counter_val + 64'($urandom_range(0, 32'(freq_eff / 5)));
          else if (pick < 22)
            counter_val = counter_val + 64'($urandom_range(0, 50));
          else
            counter_val = counter_val + ((frame_raw > jitter) ? frame_raw - jitter : 64'd0)
                          + 64'($urandom_range(0, 32'(2 * jitter)));
          send_request(MODE_TICK, counter_val, 1'b0, UNTYPED);
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (report_q.size() != 0)
      mismatches++;

    $display("Run: %0d requests (%0d reset-elapsed), %0d results checked, %0d register writes",
             reqs_sent, resets_sent, results_checked, reg_writes);
    $display("Coverage: up to %0d steps per tick, %0d results with a latched rate, %0d hold-off",
             max_steps, fps_results, holds_done);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d results outstanding", report_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> fixed_step_frame_timer.f
+incdir+rtl
rtl/fsft_pkg.sv
rtl/fsft_divider.sv
rtl/fixed_step_frame_timer.sv
tb/sv/testbench.sv
